[rtl/assert_macros.svh]
// Assertion helper macros used by sdes_encrypt_key_check_core.
// No dependencies; each file that asserts includes this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SDES_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sdes assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SDES_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sdes assertion failed");

`endif

[rtl/sdes_pkg.sv]
// S-DES key check package: field widths, stream packing and cipher tables.
// No dependencies; used by sdes_cipher and sdes_encrypt_key_check_core.
package sdes_pkg;

    localparam int unsigned BLK_W     = 8;
    localparam int unsigned KEY_W     = 10;
    localparam int unsigned IN_DATA_W = 32;   // 26 field bits, padded to whole bytes
    localparam int unsigned OUT_DATA_W = 24;  // 19 field bits, padded to whole bytes

    typedef logic [BLK_W-1:0] t_blk;
    typedef logic [KEY_W-1:0] t_key;
    typedef logic [1:0]       t_sbox [4][4];

    // Key tables number bits from the key LSB (entry n means bit n-1).
    localparam logic [3:0] C_KP10 [10] = '{4'd3, 4'd5, 4'd2, 4'd7, 4'd4,
                                           4'd10, 4'd1, 4'd9, 4'd8, 4'd6};
    localparam logic [3:0] C_KP8 [8]   = '{4'd6, 4'd3, 4'd7, 4'd4,
                                           4'd8, 4'd5, 4'd10, 4'd9};
    // Data tables number bits from the block MSB (entry 1 is the MSB).
    localparam logic [3:0] C_IP [8]    = '{4'd2, 4'd6, 4'd3, 4'd1,
                                           4'd4, 4'd8, 4'd5, 4'd7};
    localparam logic [3:0] C_FP [8]    = '{4'd4, 4'd1, 4'd3, 4'd5,
                                           4'd7, 4'd2, 4'd8, 4'd6};
    localparam logic [2:0] C_P4 [4]    = '{3'd2, 3'd4, 3'd3, 3'd1};

    localparam t_sbox C_SBOX_A = '{'{2'd1, 2'd0, 2'd3, 2'd2},
                                   '{2'd3, 2'd2, 2'd1, 2'd0},
                                   '{2'd0, 2'd2, 2'd1, 2'd3},
                                   '{2'd3, 2'd1, 2'd0, 2'd2}};
    // Modified second box.
    localparam t_sbox C_SBOX_B = '{'{2'd0, 2'd1, 2'd2, 2'd3},
                                   '{2'd2, 2'd3, 2'd1, 2'd0},
                                   '{2'd3, 2'd0, 2'd1, 2'd2},
                                   '{2'd2, 2'd1, 2'd0, 2'd3}};

endpackage

[rtl/sdes_cipher.sv]
// Two-round S-DES encryption of one block: key schedule, rounds, permutations.
// Depends on sdes_pkg for tables and types.
module sdes_cipher
    import sdes_pkg::*;
(
    input  t_blk i_plaintext,
    input  t_key i_key,
    output t_blk o_cipher
);

    // One Feistel round; vector index i is table position i of the block.
    function automatic t_blk f_round(input t_blk b, input logic [7:0] sk);
        logic [7:0] e;
        logic [1:0] va;
        logic [1:0] vb;
        logic [3:0] s;
        t_blk       r;
        e  = {b[4], b[7], b[6], b[5], b[6], b[5], b[4], b[7]} ^ sk;
        va = C_SBOX_A[{e[0], e[3]}][{e[1], e[2]}];
        vb = C_SBOX_B[{e[4], e[7]}][{e[5], e[6]}];
        s  = {vb[0], vb[1], va[0], va[1]};
        r  = b;
        for (int i = 0; i < 4; i++) begin
            r[i] = b[i] ^ s[2'(C_P4[i] - 3'd1)];
        end
        return r;
    endfunction

    logic [9:0] w_pk;
    logic [4:0] w_hi1, w_lo1, w_hi2, w_lo2;
    logic [9:0] w_join1, w_join2;
    logic [7:0] w_sk1, w_sk2;
    t_blk       w_ip, w_r1, w_sw, w_r2;

    always_comb begin
        for (int i = 0; i < 10; i++) begin
            w_pk[i] = i_key[4'(C_KP10[i] - 4'd1)];
        end
        // rotate each half right by one, then by two more
        w_hi1   = {w_pk[5], w_pk[9:6]};
        w_lo1   = {w_pk[0], w_pk[4:1]};
        w_hi2   = {w_hi1[1:0], w_hi1[4:2]};
        w_lo2   = {w_lo1[1:0], w_lo1[4:2]};
        w_join1 = {w_hi1, w_lo1};
        w_join2 = {w_hi2, w_lo2};
        for (int i = 0; i < 8; i++) begin
            w_sk1[i] = w_join1[4'(C_KP8[i] - 4'd1)];
            w_sk2[i] = w_join2[4'(C_KP8[i] - 4'd1)];
        end

        for (int i = 0; i < 8; i++) begin
            w_ip[i] = i_plaintext[3'(4'd8 - C_IP[i])];
        end
        w_r1 = f_round(w_ip, w_sk1);
        w_sw = {w_r1[3:0], w_r1[7:4]};
        w_r2 = f_round(w_sw, w_sk2);
        for (int i = 0; i < 8; i++) begin
            o_cipher[7-i] = w_r2[3'(C_FP[i] - 4'd1)];
        end
    end

endmodule

[rtl/sdes_encrypt_key_check_core.sv]
// S-DES key check top level: input register, cipher logic, result register.
// Depends on sdes_pkg, sdes_cipher and assert_macros.svh.
//
//  channel  | dir | tdata fields (low bit up)
//  s_axis   | in  | plaintext[7:0], expected_cipher[15:8], candidate_key[25:16], zero pad
//  m_axis   | out | cipher_out[7:0], key_match[8], key_echo[18:9], zero pad
//
// One item per cycle sustained while m_axis is not stalled; an accepted item is registered
// in the input stage, then in the result stage, which drives m_axis_tvalid.
// The cipher is one pass of logic between the input and result registers.
// Reset (synchronous, active low) empties both stages; no other state exists.
// A stalled result holds in place; the input register still fills behind it,
// and s_axis_tready drops only when both stages are full and m_axis is stalled.
`include "assert_macros.svh"

module sdes_encrypt_key_check_core
    import sdes_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // plaintext, expected_cipher, candidate_key
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata    // cipher_out, key_match, key_echo
);

    logic r_in_valid;
    t_blk r_in_plaintext;
    t_blk r_in_expected;
    t_key r_in_key;

    logic r_out_valid;
    t_blk r_out_cipher;
    logic r_out_match;
    t_key r_out_key;

    t_blk n_out_cipher;
    logic n_out_match;
    logic w_out_free;
    logic w_in_free;

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_in_free     = !r_in_valid || w_out_free;
    assign s_axis_tready = w_in_free;

    sdes_cipher u_cipher (
        .i_plaintext (r_in_plaintext),
        .i_key       (r_in_key),
        .o_cipher    (n_out_cipher)
    );

    assign n_out_match = (n_out_cipher == r_in_expected);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_free) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && w_in_free) begin
            r_in_plaintext <= s_axis_tdata[7:0];
            r_in_expected  <= s_axis_tdata[15:8];
            r_in_key       <= s_axis_tdata[25:16];
        end
        if (r_in_valid && w_out_free) begin
            r_out_cipher <= n_out_cipher;
            r_out_match  <= n_out_match;
            r_out_key    <= r_in_key;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out_key, r_out_match, r_out_cipher};

    // accepted item lands in the input stage
    `SDES_ASSERT_NEXT(a_accept_fills, i_clk, i_rst_n,
        s_axis_tvalid && s_axis_tready, r_in_valid)
    // a held item is never dropped while the result side is stalled
    `SDES_ASSERT_NEXT(a_in_holds, i_clk, i_rst_n,
        r_in_valid && !w_out_free, r_in_valid && $stable(r_in_key))
    // key echo follows the item that advanced
    `SDES_ASSERT_NEXT(a_key_carried, i_clk, i_rst_n,
        r_in_valid && w_out_free, r_out_valid && r_out_key == $past(r_in_key))
    // both stages full and stalled means no room upstream
    `SDES_ASSERT_NOW(a_full_backpressure, i_clk, i_rst_n,
        r_in_valid && r_out_valid && !m_axis_tready, !s_axis_tready)

endmodule
